// ===== sv/gfp_pkg.sv =====
// Shared constants, template steps and the template table of the gain frame parser.
package gfp_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned VALUE_W       = 14;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned STEP_W        = 4;
  localparam int unsigned DCNT_W        = 3;
  localparam int unsigned CAPACITY_DEF  = 24;
  localparam int unsigned MAX_DIGITS    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h21;  // '!'
  localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE      = 8'h39;

  // template steps: literal positions, number positions, terminal codes
  localparam logic [STEP_W-1:0] STEP_KP_K = 4'd0;
  localparam logic [STEP_W-1:0] STEP_KP_P = 4'd1;
  localparam logic [STEP_W-1:0] STEP_KP_E = 4'd2;
  localparam logic [STEP_W-1:0] STEP_NUM1 = 4'd3;
  localparam logic [STEP_W-1:0] STEP_KI_K = 4'd4;
  localparam logic [STEP_W-1:0] STEP_KI_I = 4'd5;
  localparam logic [STEP_W-1:0] STEP_KI_E = 4'd6;
  localparam logic [STEP_W-1:0] STEP_NUM2 = 4'd7;
  localparam logic [STEP_W-1:0] STEP_KD_K = 4'd8;
  localparam logic [STEP_W-1:0] STEP_KD_D = 4'd9;
  localparam logic [STEP_W-1:0] STEP_KD_E = 4'd10;
  localparam logic [STEP_W-1:0] STEP_NUM3 = 4'd11;
  localparam logic [STEP_W-1:0] STEP_DONE = 4'd12;
  localparam logic [STEP_W-1:0] STEP_FAIL = 4'd13;

  // expected byte at each literal step, zero elsewhere
  function automatic logic [BYTE_W-1:0] gfp_literal(input logic [STEP_W-1:0] s);
    logic [BYTE_W-1:0] c;
    case (s)
      STEP_KP_K, STEP_KI_K, STEP_KD_K: c = 8'h6B;  // k
      STEP_KP_P:                       c = 8'h70;  // p
      STEP_KI_I:                       c = 8'h69;  // i
      STEP_KD_D:                       c = 8'h64;  // d
      STEP_KP_E, STEP_KI_E, STEP_KD_E: c = 8'h3D;  // =
      default:                         c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/gfp_if.sv =====
// Channel interfaces of the gain frame parser: byte input, gain output, config writes.
interface gfp_byte_if
  import gfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gfp_gain_if
  import gfp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] kp_milli;
  logic [VALUE_W-1:0] ki_milli;
  logic [VALUE_W-1:0] kd_milli;

  modport source (output valid, output kp_milli, output ki_milli, output kd_milli,
                  input ready);
  modport sink   (input valid, input kp_milli, input ki_milli, input kd_milli,
                  output ready);
endinterface

interface gfp_cfg_if
  import gfp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/gain_frame_parser.sv =====
// Gain frame parser: matches kp=NNNNki=NNNNkd=NNNN frames byte by byte.
//
//  channel  | dir | payload                          | transaction
//  ---------+-----+----------------------------------+------------------------------
//  cfg_i    | in  | index, data                      | register write, always ready
//  in_i     | in  | rx_byte                          | one received byte
//  out_o    | out | kp_milli, ki_milli, kd_milli     | gains of one well-formed frame
//
//  One byte per cycle: the template step logic runs in the accepting cycle and a
//  closing byte loads the output register, so the result shows in the next cycle.
//  in_i stalls only while a result sits in the output register and out_o is not
//  ready. Reset clears the frame state and restores start '!' and end '#'.
module gain_frame_parser
  import gfp_pkg::*;
#(
  parameter int unsigned FRAME_CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gfp_cfg_if.sink   cfg_i,
  gfp_byte_if.sink  in_i,
  gfp_gain_if.source out_o
);

  localparam int unsigned LEN_W = $clog2(FRAME_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FRAME_CAPACITY - 1);

  logic [BYTE_W-1:0]  start_char_q, end_char_q;
  logic               collecting_q, collecting_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [VALUE_W-1:0] val1_q, val1_d, val2_q, val2_d, val3_q, val3_d;

  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] kp_q, ki_q, kd_q;

  logic               in_acc, res_fire;
  logic [BYTE_W-1:0]  b;
  logic               is_digit, is_num;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] cur_val, acc_val;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= START_CHAR_RST;
      end_char_q   <= END_CHAR_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_START_CHAR) begin
        start_char_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_END_CHAR) begin
        end_char_q <= cfg_i.data;
      end
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.rx_byte;

  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign digit    = b[3:0];
  assign is_num   = (step_q == STEP_NUM1) || (step_q == STEP_NUM2) || (step_q == STEP_NUM3);

  always_comb begin
    case (step_q)
      STEP_NUM1: cur_val = val1_q;
      STEP_NUM2: cur_val = val2_q;
      default:   cur_val = val3_q;
    endcase
  end

  // value * 10 + digit
  assign acc_val = VALUE_W'({cur_val, 3'b000}) + VALUE_W'({cur_val, 1'b0})
                 + VALUE_W'(digit);

  always_comb begin
    collecting_d = collecting_q;
    len_d        = len_q;
    step_d       = step_q;
    dcnt_d       = dcnt_q;
    val1_d       = val1_q;
    val2_d       = val2_q;
    val3_d       = val3_q;
    res_fire     = 1'b0;

    if (in_acc) begin
      if (!collecting_q) begin
        if (b == start_char_q) begin
          collecting_d = 1'b1;
          len_d        = '0;
          step_d       = STEP_KP_K;
          dcnt_d       = '0;
          val1_d       = '0;
          val2_d       = '0;
          val3_d       = '0;
        end
      end else if (b == end_char_q) begin
        collecting_d = 1'b0;
        len_d        = '0;
        res_fire     = (step_q == STEP_DONE) || (step_q == STEP_NUM3 && dcnt_q != '0);
      end else if (len_q < LEN_LIMIT) begin
        len_d = len_q + 1'b1;
        if (is_num) begin
          if (is_digit && dcnt_q < DCNT_W'(MAX_DIGITS)) begin
            case (step_q)
              STEP_NUM1: val1_d = acc_val;
              STEP_NUM2: val2_d = acc_val;
              default:   val3_d = acc_val;
            endcase
            dcnt_d = dcnt_q + 1'b1;
          end else if (dcnt_q == '0) begin
            step_d = STEP_FAIL;
          end else if (step_q == STEP_NUM3) begin
            step_d = STEP_DONE;  // trailing text ignored
          end else if (b == gfp_literal(step_q + 1'b1)) begin
            step_d = step_q + 2'd2;
            dcnt_d = '0;
          end else begin
            step_d = STEP_FAIL;
          end
        end else if (step_q < STEP_DONE) begin
          step_d = (b == gfp_literal(step_q)) ? step_q + 1'b1 : STEP_FAIL;
        end else if (step_q > STEP_FAIL) begin
          step_d = STEP_FAIL;
        end
      end else begin
        collecting_d = 1'b0;  // overflow: drop frame
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      len_q        <= '0;
      step_q       <= STEP_KP_K;
      dcnt_q       <= '0;
      val1_q       <= '0;
      val2_q       <= '0;
      val3_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      len_q        <= len_d;
      step_q       <= step_d;
      dcnt_q       <= dcnt_d;
      val1_q       <= val1_d;
      val2_q       <= val2_d;
      val3_q       <= val3_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      kp_q <= val1_q;
      ki_q <= val2_q;
      kd_q <= val3_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kp_milli = kp_q;
  assign out_o.ki_milli = ki_q;
  assign out_o.kd_milli = kd_q;

endmodule

// ===== sv/gfp_checker.sv =====
// Port-level checker for the gain frame parser and its bind.
module gfp_checker
  import gfp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [VALUE_W-1:0] kp_milli_i,
  input logic [VALUE_W-1:0] ki_milli_i,
  input logic [VALUE_W-1:0] kd_milli_i
);

  localparam logic [VALUE_W-1:0] MAX_GAIN = VALUE_W'(9999);

  // held result keeps valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kp_milli_i)
      && $stable(ki_milli_i) && $stable(kd_milli_i))
    else $error("stalled result changed");

  // input only stalls behind a pending result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // a new result follows an accepted byte
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without input transaction");

  // at most four decimal digits per gain
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kp_milli_i <= MAX_GAIN && ki_milli_i <= MAX_GAIN
      && kd_milli_i <= MAX_GAIN)
    else $error("gain out of range");

endmodule

bind gain_frame_parser gfp_checker u_gfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kp_milli_i  (out_o.kp_milli),
  .ki_milli_i  (out_o.ki_milli),
  .kd_milli_i  (out_o.kd_milli)
);

// ===== test/tb_gain_frame_parser.sv =====
// Self-checking testbench for gain_frame_parser: directed frames, then random traffic.
module tb_gain_frame_parser
  import gfp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int FRAME_CAP      = CAPACITY_DEF;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 900;
  localparam int PHASE_ITEMS    = 150;
  localparam int IDLE_PCT       = 38;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 400000;

  // template bytes per step; number positions hold zero
  localparam logic [7:0] TEMPLATE [12] = '{"k", "p", "=", 8'h00, "k", "i", "=", 8'h00,
                                           "k", "d", "=", 8'h00};

  typedef struct packed {
    logic [VALUE_W-1:0] kp;
    logic [VALUE_W-1:0] ki;
    logic [VALUE_W-1:0] kd;
  } gains_t;

  // how a byte's transaction feeds the expected gains
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_mode_t;

  typedef struct packed {
    chk_mode_t mode;
    gains_t    gains;
  } tag_t;

  typedef struct {
    bit         set_cfg;
    logic [7:0] sc;
    logic [7:0] ec;
    string      pre;
    string      body;
    int         nul_at;
    chk_mode_t  mode;
    gains_t     gains;
  } row_t;

  row_t directed_rows [19] = '{
    '{1'b0, 8'h00, 8'h00, "", "kp=0ki=0kd=0", -1, CHK_TYPED, '{14'd0, 14'd0, 14'd0}},
    '{1'b0, 8'h00, 8'h00, "", "kp=9999ki=9999kd=9999", -1, CHK_TYPED,
      '{14'd9999, 14'd9999, 14'd9999}},
    '{1'b0, 8'h00, 8'h00, "#zz", "kp=12ki=345kd=6789xyz", -1, CHK_TYPED,
      '{14'd12, 14'd345, 14'd6789}},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=2kd=33333", -1, CHK_TYPED, '{14'd1, 14'd2, 14'd3333}},
    '{1'b0, 8'h00, 8'h00, "", "kp=12345ki=1kd=1", -1, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=12345kd=1", -1, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "kp= 1ki=1kd=1", -1, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=-1kd=1", -1, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=2kd=", -1, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=2kd=3zz", 12, CHK_TYPED, '{14'd1, 14'd2, 14'd3}},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=2kd", 3, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=2kd=3aaaaaaaaaaa", -1, CHK_TYPED,
      '{14'd1, 14'd2, 14'd3}},
    '{1'b0, 8'h00, 8'h00, "", "kp=1ki=2kd=3aaaaaaaaaaaa", -1, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "!kp=1ki=2kd=3", -1, CHK_NONE, '0},
    '{1'b0, 8'h00, 8'h00, "", "kq=1ki=2kd=3", -1, CHK_NONE, '0},
    '{1'b1, "$", "$", "", "kp=4ki=5kd=6", -1, CHK_TYPED, '{14'd4, 14'd5, 14'd6}},
    '{1'b1, 8'h00, 8'hFF, "", "kp=7ki=8kd=9", -1, CHK_TYPED, '{14'd7, 14'd8, 14'd9}},
    '{1'b1, 8'hFF, 8'h00, "", "kp=1234ki=5678kd=9012", -1, CHK_MODEL, '0},
    '{1'b1, START_CHAR_RST, END_CHAR_RST, "", "kp=3ki=0kd=0010", -1, CHK_MODEL, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  gfp_cfg_if  cfg_ch ();
  gfp_byte_if byte_ch ();
  gfp_gain_if gain_ch ();

  gain_frame_parser #(.FRAME_CAPACITY(FRAME_CAP)) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch),
    .in_i  (byte_ch),
    .out_o (gain_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // frame tracker state
  logic [7:0]         pred_start = START_CHAR_RST;
  logic [7:0]         pred_end   = END_CHAR_RST;
  bit                 in_frame   = 1'b0;
  int                 frame_len  = 0;
  logic [STEP_W-1:0]  tstep      = STEP_KP_K;
  int                 ndigits    = 0;
  logic [VALUE_W-1:0] acc [3]    = '{default: '0};

  gains_t     gains_q [$];
  tag_t       byte_tag;
  logic [7:0] cur_start = START_CHAR_RST;
  logic [7:0] cur_end   = END_CHAR_RST;
  int         tx_idle_pct = IDLE_PCT;
  int         rx_idle_pct = IDLE_PCT;
  int         hold_left   = 0;
  int         n_errors    = 0;
  int         n_bytes     = 0;
  int         n_results   = 0;
  int         n_writes    = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // advance the frame tracker by one byte; returns 1 when a frame closes well formed
  function automatic bit advance_frame(input logic [7:0] b, output gains_t g);
    logic [VALUE_W-1:0] d;
    bit                 is_digit;
    int                 slot;
    g        = '0;
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    d        = VALUE_W'(b - CHAR_ZERO);
    if (!in_frame) begin
      if (b == pred_start) begin
        in_frame  = 1'b1;
        frame_len = 0;
        tstep     = STEP_KP_K;
        ndigits   = 0;
        acc       = '{default: '0};
      end
      return 1'b0;
    end
    // end char wins over everything, even when equal to start char
    if (b == pred_end) begin
      in_frame  = 1'b0;
      frame_len = 0;
      g         = '{acc[0], acc[1], acc[2]};
      return (tstep == STEP_DONE) || (tstep == STEP_NUM3 && ndigits > 0);
    end
    if (frame_len >= FRAME_CAP - 1) begin
      in_frame = 1'b0;
      return 1'b0;
    end
    frame_len++;
    case (tstep)
      STEP_NUM1, STEP_NUM2, STEP_NUM3: begin
        slot = (tstep == STEP_NUM1) ? 0 : (tstep == STEP_NUM2) ? 1 : 2;
        if (is_digit && ndigits < MAX_DIGITS) begin
          acc[slot] = VALUE_W'(acc[slot] * 10 + d);
          ndigits++;
        end else if (ndigits == 0) begin
          tstep = STEP_FAIL;
        end else if (tstep == STEP_NUM3) begin
          tstep = STEP_DONE;
        end else if (b == TEMPLATE[tstep + 1]) begin
          tstep   = STEP_W'(tstep + 2);
          ndigits = 0;
        end else begin
          tstep = STEP_FAIL;
        end
      end
      STEP_DONE, STEP_FAIL: ;
      default: tstep = (b == TEMPLATE[tstep]) ? STEP_W'(tstep + 1) : STEP_FAIL;
    endcase
    return 1'b0;
  endfunction

  // observe all three channels at the clock edge
  always @(posedge clk) begin
    gains_t exp_g;
    gains_t got_g;
    bit     fired;
    if (rst_n) begin
      if (gain_ch.valid && gain_ch.ready) begin
        n_results++;
        if (gains_q.size() == 0) begin
          report_mismatch($sformatf("unexpected gains %0d/%0d/%0d", gain_ch.kp_milli,
                                    gain_ch.ki_milli, gain_ch.kd_milli));
        end else begin
          exp_g = gains_q.pop_front();
          if (gain_ch.kp_milli !== exp_g.kp)
            report_mismatch($sformatf("kp %0d, want %0d", gain_ch.kp_milli, exp_g.kp));
          if (gain_ch.ki_milli !== exp_g.ki)
            report_mismatch($sformatf("ki %0d, want %0d", gain_ch.ki_milli, exp_g.ki));
          if (gain_ch.kd_milli !== exp_g.kd)
            report_mismatch($sformatf("kd %0d, want %0d", gain_ch.kd_milli, exp_g.kd));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_START_CHAR) pred_start = cfg_ch.data;
        else if (cfg_ch.index == CFG_END_CHAR) pred_end = cfg_ch.data;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        n_bytes++;
        fired = advance_frame(byte_ch.rx_byte, got_g);
        if (byte_tag.mode == CHK_TYPED) gains_q.push_back(byte_tag.gains);
        else if (byte_tag.mode == CHK_MODEL && fired) gains_q.push_back(got_g);
      end
    end
  end

  // gain sink: random back-pressure plus an occasional long hold
  initial begin
    gain_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        gain_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        gain_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input tag_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    byte_tag        <= t;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic send_frame(input logic [7:0] frame[$], input chk_mode_t mode,
                            input gains_t typed);
    tag_t t;
    foreach (frame[i]) begin
      // typed gains are attached to the closing byte only
      t.mode  = (mode == CHK_TYPED && i != frame.size() - 1) ? CHK_NONE : mode;
      t.gains = typed;
      send_byte(frame[i], t);
    end
  endtask

  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (gains_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write to an unused index, then both characters
  task automatic write_regs(input logic [7:0] s, input logic [7:0] e);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= 8'($urandom_range(2, 255));
    cfg_ch.data  <= 8'($urandom());
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_START_CHAR;
    cfg_ch.data  <= s;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_END_CHAR;
    cfg_ch.data  <= e;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_start = s;
    cur_end   = e;
    n_writes += 3;
  endtask

  initial begin
    logic [7:0] fq [$];
    logic [7:0] sc;
    logic [7:0] ec;
    int         rand_bytes;
    int         phase_end;
    int         ndig;
    int         kind;
    int         n_phases;
    rand_bytes      = 0;
    n_phases        = 0;
    rst_n           = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    byte_tag        = '{CHK_NONE, '0};
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_cfg) begin
        settle();
        write_regs(directed_rows[r].sc, directed_rows[r].ec);
      end
      fq.delete();
      for (int i = 0; i < directed_rows[r].pre.len(); i++) fq.push_back(directed_rows[r].pre[i]);
      fq.push_back(cur_start);
      for (int i = 0; i < directed_rows[r].body.len(); i++) begin
        if (i == directed_rows[r].nul_at) fq.push_back(8'h00);
        fq.push_back(directed_rows[r].body[i]);
      end
      fq.push_back(cur_end);
      send_frame(fq, directed_rows[r].mode, directed_rows[r].gains);
    end

    for (int p = 0; rand_bytes < RANDOM_ITEMS; p++) begin
      settle();
      case (p % 6)
        0: begin sc = START_CHAR_RST; ec = END_CHAR_RST; end
        1: begin sc = 8'h00; ec = 8'hFF; end
        2: begin sc = 8'hFF; ec = 8'h00; end
        4: begin sc = 8'($urandom()); ec = 8'($urandom()); end
        default: begin
          // keep delimiters off the template alphabet so frames can complete
          do sc = 8'($urandom());
          while ((sc >= CHAR_ZERO && sc <= CHAR_NINE) || sc inside {"k", "p", "i", "d", "="});
          do ec = 8'($urandom());
          while ((ec >= CHAR_ZERO && ec <= CHAR_NINE) || ec inside {"k", "p", "i", "d", "="});
          if (p % 6 == 3) ec = sc;
        end
      endcase
      write_regs(sc, ec);
      n_phases++;
      tx_idle_pct = (p == 2 || p == 4) ? 0 : IDLE_PCT;
      rx_idle_pct = (p == 4) ? 0 : IDLE_PCT;
      if (p == 2) hold_left = HOLD_CYCLES;
      phase_end = rand_bytes + PHASE_ITEMS;
      while (rand_bytes < phase_end) begin
        fq.delete();
        if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) fq.push_back(8'($urandom()));
        fq.push_back(cur_start);
        for (int f = 0; f < 3; f++) begin
          fq.push_back("k");
          fq.push_back((f == 0) ? "p" : (f == 1) ? "i" : "d");
          fq.push_back("=");
          ndig = ($urandom_range(99) < 5) ? 5 : $urandom_range(1, 4);
          repeat (ndig) fq.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(99) < 25)
          repeat ($urandom_range(1, 6)) fq.push_back(8'($urandom_range(32, 126)));
        kind = $urandom_range(99);
        if (kind < 8)
          fq.insert($urandom_range(1, fq.size() - 1), 8'($urandom()));
        else if (kind < 14)
          fq[$urandom_range(1, fq.size() - 1)] = 8'($urandom());
        else if (kind < 18)
          fq.insert($urandom_range(1, fq.size() - 1), 8'h00);
        else if (kind < 22)
          fq.insert($urandom_range(1, fq.size() - 1), $urandom_range(1) ? " " : "-");
        else if (kind < 26)
          repeat ($urandom_range(8, 16)) fq.push_back("z");
        // a few frames lose their end char and run into the next one
        if (kind < 96) fq.push_back(cur_end);
        send_frame(fq, CHK_MODEL, '0);
        rand_bytes += fq.size();
      end
    end

    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
    settle();
    if (gains_q.size() != 0)
      report_mismatch($sformatf("%0d expected gain sets never arrived", gains_q.size()));
    $display("Run covered %0d byte transactions and %0d gain results,", n_bytes, n_results);
    $display("with %0d register writes across %0d random phases.", n_writes, n_phases);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
